// ===== src/mod10_check_digit_append_macros.svh =====
// ----------------------------------------------------------------------------
// mod10_check_digit_append assertion macros
// Shared forms for the concurrent checks in the check digit block.
// ----------------------------------------------------------------------------
`ifndef MOD10_CHECK_DIGIT_APPEND_MACROS_SVH
`define MOD10_CHECK_DIGIT_APPEND_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define MCDA_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define MCDA_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/mcda_pkg.sv =====
// ----------------------------------------------------------------------------
// mcda_pkg
// Widths, reciprocal constants and digit helpers for the check digit block.
// ----------------------------------------------------------------------------
package mcda_pkg;

  localparam int SN_W    = 24;
  localparam int EXT_W   = 27;
  localparam int CHK_W   = 4;
  localparam int LOW_W   = 24;
  localparam int Q_W     = 14;  // low seven digits divided by 1000, up to 9999
  localparam int R_W     = 10;  // remainder by 1000
  localparam int PAIR_W  = 7;   // two decimal digits
  localparam int SUM_W   = 6;   // weighted digit sum, at most 63
  localparam int NUM_STAGES = 8;

  localparam logic [SN_W-1:0]  SEVEN_DIGIT_LIMIT = SN_W'(10000000);
  localparam logic [20:0]      RECIP_1000  = 21'd1073741;  // floor(2^30 / 1000)
  localparam logic [10:0]      THOUSAND    = 11'd1000;
  localparam logic [12:0]      RECIP_100_Q = 13'd5243;     // ceil(2^19 / 100)
  localparam logic [5:0]       RECIP_100_R = 6'd41;        // ceil(2^12 / 100)
  localparam logic [6:0]       HUNDRED     = 7'd100;
  localparam logic [6:0]       TENS_RECIP  = 7'd103;       // ceil(2^10 / 10)
  localparam logic [CHK_W-1:0] RADIX       = CHK_W'(10);

  // Which digit of a pair carries the weight of three.
  localparam logic TRIPLE_HI = 1'b1;
  localparam logic TRIPLE_LO = 1'b0;

  // Tens digit of a value below 100.
  function automatic logic [3:0] tens_of(input logic [PAIR_W-1:0] v);
    logic [13:0] p;
    p = 14'(v) * 14'(TENS_RECIP);
    return p[13:10];
  endfunction

  // Decimal digit sum of three times a digit.
  function automatic logic [3:0] ds3(input logic [3:0] d);
    logic [3:0] s;
    case (d)
      4'd0:    s = 4'd0;
      4'd1:    s = 4'd3;
      4'd2:    s = 4'd6;
      4'd3:    s = 4'd9;
      4'd4:    s = 4'd3;
      4'd5:    s = 4'd6;
      4'd6:    s = 4'd9;
      4'd7:    s = 4'd3;
      4'd8:    s = 4'd6;
      4'd9:    s = 4'd9;
      default: s = 4'd0;
    endcase
    return s;
  endfunction

  // Weighted digit sum of a two-digit pair, one digit weighted by three.
  function automatic logic [4:0] pair_wsum(input logic [PAIR_W-1:0] v,
                                           input logic hi_triple);
    logic [3:0] hi;
    logic [3:0] lo;
    logic [3:0] whi;
    logic [3:0] wlo;
    hi  = tens_of(v);
    lo  = 4'(v - PAIR_W'(7'(hi) * 7'(RADIX)));
    whi = hi_triple ? ds3(hi) : hi;
    wlo = hi_triple ? lo : ds3(lo);
    return 5'(whi) + 5'(wlo);
  endfunction

endpackage

// ===== src/mod10_check_digit_append.sv =====
// Throughput: one transaction per cycle while m_tready does not stall the output,
// through an eight-register pipeline.
// Each stage moves on when it is empty or its successor moves, so bubbles close up.
// Reset (rst, synchronous) clears all stage valid bits; no payload is reset.
// ----------------------------------------------------------------------------
// mod10_check_digit_append
// Appends a weight 1-3 mod-10 check digit to the low seven decimal digits.
// ----------------------------------------------------------------------------
`include "mod10_check_digit_append_macros.svh"

module mod10_check_digit_append (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [mcda_pkg::SN_W-1:0] s_tdata,  // [23:0] serial_number
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [31:0]              m_tdata,   // [26:0] extended_number,
                                              // [30:27] check_digit, [31] zero
  output logic                     m_tuser    // [0] too_many_digits
);
  import mcda_pkg::*;

  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES-1:0] rdy;
  logic [NUM_STAGES-1:0] ld;

  // Stage payloads
  logic [SN_W-1:0]   sn;
  logic [LOW_W-1:0]  low7 [1:6];
  logic [6:1]        ovf;
  logic [Q_W-1:0]    q_est;
  logic [Q_W-1:0]    q_div;
  logic [R_W-1:0]    r_div;
  logic [Q_W-1:0]    q_carry;
  logic [R_W-1:0]    r_carry;
  logic [PAIR_W-1:0] a_pair;
  logic [3:0]        b_digit;
  logic [PAIR_W-1:0] a_pair5;
  logic [3:0]        b_digit5;
  logic [PAIR_W-1:0] c_pair;
  logic [PAIR_W-1:0] d_pair;
  logic [SUM_W-1:0]  wsum;
  logic [EXT_W-1:0]  ext_number;
  logic [CHK_W-1:0]  check_digit;
  logic              too_many;

  // Combinational stage logic
  logic              over_next;
  logic [LOW_W-1:0]  low7_next;
  logic [43:0]       prod_q;
  logic [10:0]       rem_raw;
  logic              rem_fix;
  logic [25:0]       prod_a;
  logic [15:0]       prod_b;
  logic [SUM_W-1:0]  wsum_next;
  logic [3:0]        sum_tens;
  logic [CHK_W-1:0]  sum_mod;
  logic [CHK_W-1:0]  check_next;

  // Ready chain: a stage can load when it is empty or its content moves on.
  always_comb begin
    rdy[NUM_STAGES-1] = !vld[NUM_STAGES-1] || m_tready;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
    ld[0] = rdy[0] && s_tvalid;
    for (int i = 1; i < NUM_STAGES; i++) begin
      ld[i] = rdy[i] && vld[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= s_tvalid;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // Input is below twice the limit, so one subtract brings it to seven digits.
  assign over_next = (sn >= SEVEN_DIGIT_LIMIT);
  assign low7_next = over_next ? sn - SEVEN_DIGIT_LIMIT : sn;

  // The floor reciprocal may fall one short; the remainder step corrects it.
  assign prod_q  = 44'(low7[1]) * 44'(RECIP_1000);
  assign rem_raw = low7[2][10:0] - 11'(25'(q_est) * 25'(THOUSAND));
  assign rem_fix = (rem_raw >= THOUSAND);

  assign prod_a = 26'(q_div) * 26'(RECIP_100_Q);
  assign prod_b = 16'(r_div) * 16'(RECIP_100_R);

  // Digits, most significant first: a_pair = d0 d1, c_pair = d2 d3,
  // b_digit = d4, d_pair = d5 d6. Weights 1 3 1 3 1 3 1.
  assign wsum_next = SUM_W'(pair_wsum(a_pair5, TRIPLE_LO))
                   + SUM_W'(pair_wsum(c_pair, TRIPLE_LO))
                   + SUM_W'(b_digit5)
                   + SUM_W'(pair_wsum(d_pair, TRIPLE_HI));

  assign sum_tens   = tens_of(PAIR_W'(wsum));
  assign sum_mod    = CHK_W'(PAIR_W'(wsum) - PAIR_W'(7'(sum_tens) * 7'(RADIX)));
  assign check_next = (sum_mod == '0) ? '0 : RADIX - sum_mod;

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      sn <= s_tdata;
    end
    if (ld[1]) begin
      low7[1] <= low7_next;
      ovf[1]  <= over_next;
    end
    for (int k = 2; k <= 6; k++) begin
      if (ld[k]) begin
        low7[k] <= low7[k-1];
        ovf[k]  <= ovf[k-1];
      end
    end
    if (ld[2]) begin
      q_est <= prod_q[43:30];
    end
    if (ld[3]) begin
      q_div <= q_est + Q_W'(rem_fix);
      r_div <= rem_fix ? R_W'(rem_raw - THOUSAND) : R_W'(rem_raw);
    end
    if (ld[4]) begin
      a_pair  <= prod_a[25:19];
      b_digit <= prod_b[15:12];
      q_carry <= q_div;
      r_carry <= r_div;
    end
    if (ld[5]) begin
      a_pair5  <= a_pair;
      b_digit5 <= b_digit;
      c_pair   <= q_carry[PAIR_W-1:0] - PAIR_W'(7'(a_pair) * HUNDRED);
      d_pair   <= r_carry[PAIR_W-1:0] - PAIR_W'(7'(b_digit) * HUNDRED);
    end
    if (ld[6]) begin
      wsum <= wsum_next;
    end
    if (ld[7]) begin
      ext_number  <= EXT_W'(low7[6]) * EXT_W'(RADIX) + EXT_W'(check_next);
      check_digit <= check_next;
      too_many    <= ovf[6];
    end
  end

  assign s_tready = rdy[0];
  assign m_tvalid = vld[NUM_STAGES-1];
  assign m_tdata  = {1'b0, check_digit, ext_number};
  assign m_tuser  = too_many;

  `MCDA_ASSERT_IMP(a_check_range, m_tvalid, check_digit < RADIX, "check digit above nine")
  `MCDA_ASSERT_IMP(a_rem_range, vld[3], r_div < R_W'(THOUSAND), "remainder out of range")
  `MCDA_ASSERT_IMP(a_pair_range, vld[5], (c_pair < HUNDRED) && (d_pair < HUNDRED), "pair above 99")
  `MCDA_ASSERT_IMP(a_ready_empty, !m_tvalid, s_tready, "input stalled with output empty")
  `MCDA_ASSERT_NXT(a_capture, s_tvalid && s_tready, vld[0], "accepted transaction not captured")

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams serial numbers into the check digit block under random bursts on
// the input side and a changing stall pattern on the output side. Every
// result is compared field by field against an independent prediction.
// ----------------------------------------------------------------------------
module testbench;
  import mcda_pkg::*;

  localparam int unsigned DIGIT_COUNT = 7;
  localparam int unsigned DECIMAL     = 10;
  localparam int unsigned DIGIT_SPAN  = 10000000;
  localparam int          RANDOM_ITEMS = 2000;
  localparam int          DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [EXT_W-1:0] extended_number;
    logic [CHK_W-1:0] check_digit;
    logic             too_many_digits;
  } check_result_t;

  class check_digit_board;
    check_result_t expected_results[$];
    int            errors = 0;

    // Weights run 1,3,1,3,1,3,1 from the most significant of seven digits,
    // so counted from the least significant digit the odd positions triple.
    function check_result_t predict(logic [SN_W-1:0] sn);
      int unsigned   low7;
      int unsigned   rest;
      int unsigned   total;
      int unsigned   w;
      check_result_t r;
      low7  = int'(sn) % DIGIT_SPAN;
      rest  = low7;
      total = 0;
      for (int k = 0; k < DIGIT_COUNT; k++) begin
        w     = (rest % DECIMAL) * ((k % 2 == 1) ? 3 : 1);
        total += (w % DECIMAL) + (w / DECIMAL);
        rest  /= DECIMAL;
      end
      r.check_digit     = CHK_W'((DECIMAL - (total % DECIMAL)) % DECIMAL);
      r.extended_number = EXT_W'(low7 * DECIMAL + r.check_digit);
      r.too_many_digits = (sn >= SEVEN_DIGIT_LIMIT);
      return r;
    endfunction

    function void note_input(logic [SN_W-1:0] sn);
      expected_results.push_back(predict(sn));
    endfunction

    task report_mismatch(string what, longint got, longint want);
      $display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
      errors++;
    endtask

    task check_result(logic [31:0] tdata, logic tuser);
      check_result_t want;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected transaction", tdata, 0);
      end else begin
        want = expected_results.pop_front();
        if (tdata[EXT_W-1:0] !== want.extended_number)
          report_mismatch("extended_number", tdata[EXT_W-1:0], want.extended_number);
        if (tdata[EXT_W+CHK_W-1:EXT_W] !== want.check_digit)
          report_mismatch("check_digit", tdata[EXT_W+CHK_W-1:EXT_W], want.check_digit);
        if (tdata[31] !== 1'b0)
          report_mismatch("tdata pad bit", tdata[31], 0);
        if (tuser !== want.too_many_digits)
          report_mismatch("too_many_digits", tuser, want.too_many_digits);
      end
    endtask

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            s_tvalid = 1'b0;
  logic            s_tready;
  logic [SN_W-1:0] s_tdata = '0;   // [23:0] serial_number
  logic            m_tvalid;
  logic            m_tready = 1'b0;
  logic [31:0]     m_tdata;        // [26:0] extended_number, [30:27] check_digit, [31] zero
  logic            m_tuser;        // [0] too_many_digits

  check_digit_board board = new();

  mod10_check_digit_append dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #4ms;
    $display("mod10_check_digit_append test failed");
    $finish;
  end

  // Output side: the stall pattern switches at random between
  // always ready, random ready at two densities and a periodic stall.
  initial begin
    int mode;
    int span;
    int phase;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(32, 256);
      for (phase = 0; phase < span; phase++) begin
        @(posedge clk);
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= ($urandom_range(0, 9) < 7);
          2: m_tready <= (phase % 5 != 0);
          default: m_tready <= ($urandom_range(0, 9) < 3);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      board.check_result(m_tdata, m_tuser);
  end

  // Holds one transaction until it is accepted; tvalid stays high for a
  // back-to-back follower.
  task automatic send_serial(input logic [SN_W-1:0] sn);
    s_tdata  <= sn;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    board.note_input(sn);
  endtask

  task automatic idle_gap();
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [SN_W-1:0] random_serial();
    case ($urandom_range(0, 3))
      0:       return SN_W'($urandom_range(0, 99));
      1:       return SN_W'($urandom_range(SEVEN_DIGIT_LIMIT, 24'hFFFFFF));
      default: return SN_W'($urandom_range(0, 24'hFFFFFF));
    endcase
  endfunction

  initial begin
    logic [SN_W-1:0] directed[$];
    int sent;
    int burst;
    // Zero, the seven digit edges, inputs beyond seven digits, weighted sums
    // that are multiples of ten, all nines in tripled places, bit patterns.
    directed = '{24'd0, 24'd9999999, 24'd10000000, 24'd16777215, 24'd9999998,
                 24'd1234567, 24'd10000001, 24'd91, 24'd10000091, 24'd9090909,
                 24'd909090, 24'hAAAAAA, 24'h555555, 24'd1, 24'd10, 24'd7,
                 24'd1000000, 24'd8765432, 24'd16777214, 24'd12345678};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    foreach (directed[i]) begin
      send_serial(directed[i]);
      if (i % 4 == 3)
        idle_gap();
    end
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 32);
      for (int b = 0; b < burst && sent < RANDOM_ITEMS; b++) begin
        send_serial(random_serial());
        sent++;
      end
      idle_gap();
    end
    s_tvalid <= 1'b0;
    while (board.pending() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0)
      $display("mod10_check_digit_append test passed");
    else
      $display("mod10_check_digit_append test failed");
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+src
src/mcda_pkg.sv
src/mod10_check_digit_append.sv
tb/testbench.sv
